>>> hw/rtl/bezier_curve_point_eval_unit_macros.svh
// ----------------------------------------------------------------------------
// Bezier curve point evaluator assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_POINT_EVAL_UNIT_MACROS_SVH
`define BEZIER_CURVE_POINT_EVAL_UNIT_MACROS_SVH

// same-cycle implication
`define BZEVAL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BZEVAL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/bzeval_pkg.sv
// ----------------------------------------------------------------------------
// Bezier curve point evaluator package
// Sizes, request and response types, and control structs shared by the unit.
// ----------------------------------------------------------------------------
package bzeval_pkg;

   localparam int MAX_POINTS     = 16;
   localparam int IDX_W          = $clog2(MAX_POINTS);
   localparam int CNT_W          = $clog2(MAX_POINTS + 1);
   localparam int COORD_W        = 32;
   localparam int T_W            = 17;
   localparam int FRAC_W         = 16;
   localparam int ONE_Q16        = 65536;
   localparam int DIFF_W         = COORD_W + 1;
   localparam int PROD_W         = DIFF_W + T_W + 1;
   localparam int LEVEL_SPACING  = 4;
   localparam int GAP_W          = $clog2(LEVEL_SPACING);
   localparam int NP_W           = 5;
   localparam int NP_RESET       = 4;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_IDX_LSB    = 2;

   localparam logic [CSR_ADDR_W-CSR_IDX_LSB-1:0] CSR_IDX_NUM_POINTS = 1'b0;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_EVAL = 1'b1
   } action_type;

   typedef struct packed {
      action_type          action;
      logic [3:0]          point_index;
      logic signed [31:0]  point_x;
      logic signed [31:0]  point_y;
      logic signed [31:0]  point_z;
      logic [16:0]         curve_param;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  curve_x;
      logic signed [31:0]  curve_y;
      logic signed [31:0]  curve_z;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      logic             valid;
      logic             first;
      logic             pass;
      logic             last;
      logic             from_store;
      logic [IDX_W-1:0] idx;
   } rd_tag_type;

   typedef struct packed {
      logic             wr_en;
      logic             res_en;
      logic [IDX_W-1:0] idx;
   } wb_type;

endpackage

>>> hw/rtl/bzeval_vec_mem.sv
// ----------------------------------------------------------------------------
// Bezier point memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bzeval_vec_mem (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [bzeval_pkg::IDX_W-1:0]       wr_idx,
   input  bzeval_pkg::point_type              wr_data,
   input  logic [bzeval_pkg::IDX_W-1:0]       rd_idx,
   output bzeval_pkg::point_type              rd_data
);

   bzeval_pkg::point_type store_ff [bzeval_pkg::MAX_POINTS];
   bzeval_pkg::point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_idx];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bzeval_lerp_unit.sv
// ----------------------------------------------------------------------------
// Bezier interpolation pipeline
// Computes a + floor(t * (b - a) / 2^16) per coordinate over three stages:
// difference, multiply, add and write back.
// ----------------------------------------------------------------------------
module bzeval_lerp_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  bzeval_pkg::rd_tag_type         rd_tag,
   input  logic [bzeval_pkg::T_W-1:0]     curve_t,
   input  bzeval_pkg::point_type          store_data,
   input  bzeval_pkg::point_type          work_data,
   output bzeval_pkg::wb_type             wb,
   output bzeval_pkg::point_type          wb_data
);

   bzeval_pkg::rd_tag_type tag1_ff;
   bzeval_pkg::point_type  rd_pt;
   bzeval_pkg::point_type  a_ff;
   bzeval_pkg::point_type  a_in;
   bzeval_pkg::point_type  keep2_in;
   bzeval_pkg::point_type  keep2_ff;
   bzeval_pkg::point_type  keep3_ff;
   bzeval_pkg::wb_type     s2_in;
   bzeval_pkg::wb_type     s2_ff;
   bzeval_pkg::wb_type     s3_ff;

   logic signed [bzeval_pkg::DIFF_W-1:0] dx_in;
   logic signed [bzeval_pkg::DIFF_W-1:0] dy_in;
   logic signed [bzeval_pkg::DIFF_W-1:0] dz_in;
   logic signed [bzeval_pkg::DIFF_W-1:0] dx_ff;
   logic signed [bzeval_pkg::DIFF_W-1:0] dy_ff;
   logic signed [bzeval_pkg::DIFF_W-1:0] dz_ff;
   logic signed [bzeval_pkg::PROD_W-1:0] px_in;
   logic signed [bzeval_pkg::PROD_W-1:0] py_in;
   logic signed [bzeval_pkg::PROD_W-1:0] pz_in;
   logic signed [bzeval_pkg::PROD_W-1:0] px_ff;
   logic signed [bzeval_pkg::PROD_W-1:0] py_ff;
   logic signed [bzeval_pkg::PROD_W-1:0] pz_ff;
   logic signed [bzeval_pkg::T_W:0]      t_s;

   assign t_s = $signed({1'b0, curve_t});

   always_comb begin
      rd_pt = tag1_ff.from_store ? store_data : work_data;
   end

   always_comb begin
      s2_in    = '0;
      a_in     = a_ff;
      keep2_in = a_ff;
      dx_in    = '0;
      dy_in    = '0;
      dz_in    = '0;
      if (tag1_ff.valid) begin
         a_in = rd_pt;
         if (tag1_ff.pass) begin
            s2_in.res_en = 1'b1;
            keep2_in     = rd_pt;
         end else if (!tag1_ff.first) begin
            s2_in.wr_en  = !tag1_ff.last;
            s2_in.res_en = tag1_ff.last;
            s2_in.idx    = tag1_ff.idx - bzeval_pkg::IDX_W'(1);
            dx_in = bzeval_pkg::DIFF_W'(rd_pt.x) - bzeval_pkg::DIFF_W'(a_ff.x);
            dy_in = bzeval_pkg::DIFF_W'(rd_pt.y) - bzeval_pkg::DIFF_W'(a_ff.y);
            dz_in = bzeval_pkg::DIFF_W'(rd_pt.z) - bzeval_pkg::DIFF_W'(a_ff.z);
         end
      end
   end

   always_comb begin
      px_in = bzeval_pkg::PROD_W'(dx_ff) * bzeval_pkg::PROD_W'(t_s);
      py_in = bzeval_pkg::PROD_W'(dy_ff) * bzeval_pkg::PROD_W'(t_s);
      pz_in = bzeval_pkg::PROD_W'(dz_ff) * bzeval_pkg::PROD_W'(t_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         s2_ff   <= '0;
         s3_ff   <= '0;
      end else begin
         tag1_ff <= rd_tag;
         s2_ff   <= s2_in;
         s3_ff   <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      keep2_ff <= keep2_in;
      keep3_ff <= keep2_ff;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
   end

   always_comb begin
      wb        = s3_ff;
      wb_data.x = $signed(keep3_ff.x + px_ff[bzeval_pkg::FRAC_W +: bzeval_pkg::COORD_W]);
      wb_data.y = $signed(keep3_ff.y + py_ff[bzeval_pkg::FRAC_W +: bzeval_pkg::COORD_W]);
      wb_data.z = $signed(keep3_ff.z + pz_ff[bzeval_pkg::FRAC_W +: bzeval_pkg::COORD_W]);
   end

endmodule

>>> hw/rtl/bzeval_sequencer.sv
// ----------------------------------------------------------------------------
// Bezier level sequencer
// Walks the de Casteljau levels, issuing one memory read per cycle, spacing
// short levels so write-back lands before the next level reads it.
// ----------------------------------------------------------------------------
module bzeval_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [bzeval_pkg::CNT_W-1:0]   n_pts,
   input  logic                           res_en,
   input  logic                           out_free,
   output bzeval_pkg::rd_tag_type         rd_tag,
   output logic                           busy,
   output logic                           push
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_GAP,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   state_type                        state_ff;
   state_type                        state_in;
   logic [bzeval_pkg::IDX_W-1:0]     m_ff;
   logic [bzeval_pkg::IDX_W-1:0]     m_in;
   logic [bzeval_pkg::IDX_W-1:0]     j_ff;
   logic [bzeval_pkg::IDX_W-1:0]     j_in;
   logic                             first_lvl_ff;
   logic                             first_lvl_in;
   logic [bzeval_pkg::GAP_W-1:0]     gap_ff;
   logic [bzeval_pkg::GAP_W-1:0]     gap_in;
   logic                             pass;

   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      j_in         = j_ff;
      first_lvl_in = first_lvl_ff;
      gap_in       = gap_ff;
      rd_tag       = '0;
      push         = 1'b0;
      pass         = (m_ff == '0);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               m_in         = bzeval_pkg::IDX_W'(n_pts - bzeval_pkg::CNT_W'(1));
               j_in         = '0;
               first_lvl_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         ST_RUN: begin
            rd_tag.valid      = 1'b1;
            rd_tag.idx        = j_ff;
            rd_tag.first      = (j_ff == '0) && !pass;
            rd_tag.pass       = pass;
            rd_tag.last       = pass || (m_ff == bzeval_pkg::IDX_W'(1));
            rd_tag.from_store = first_lvl_ff;
            if (pass || (j_ff == m_ff)) begin
               if (m_ff <= bzeval_pkg::IDX_W'(1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  m_in         = m_ff - bzeval_pkg::IDX_W'(1);
                  j_in         = '0;
                  first_lvl_in = 1'b0;
                  if (int'(m_ff) < bzeval_pkg::LEVEL_SPACING) begin
                     gap_in   = bzeval_pkg::GAP_W'(bzeval_pkg::LEVEL_SPACING - int'(m_ff));
                     state_in = ST_GAP;
                  end
               end
            end else begin
               j_in = j_ff + bzeval_pkg::IDX_W'(1);
            end
         end
         ST_GAP: begin
            gap_in = gap_ff - bzeval_pkg::GAP_W'(1);
            if (gap_ff == bzeval_pkg::GAP_W'(1)) begin
               state_in = ST_RUN;
            end
         end
         ST_DRAIN: begin
            if (res_en) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         m_ff         <= '0;
         j_ff         <= '0;
         first_lvl_ff <= 1'b0;
         gap_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         m_ff         <= m_in;
         j_ff         <= j_in;
         first_lvl_ff <= first_lvl_in;
         gap_ff       <= gap_in;
      end
   end

endmodule

>>> hw/rtl/bezier_curve_point_eval_unit.sv
// ----------------------------------------------------------------------------
// Bezier curve point evaluation unit
// De Casteljau evaluation of a 3D Q16.16 curve from a control-point memory,
// with a working memory holding each interpolation level.
// ----------------------------------------------------------------------------
// Load request: written to the point memory, no response.
// Evaluate request: one memory read per cycle through each level,
// plus spacing on short levels.
// One request in flight: next taken once an evaluate's response is pushed,
// later while a previous response is stalled.
// Reset: control cleared, num_points back to 4; point memories keep contents.
// ----------------------------------------------------------------------------
module bezier_curve_point_eval_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bzeval_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bzeval_pkg::rsp_type                 rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bzeval_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bzeval_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [bzeval_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);

   logic                              req_acc;
   logic                              load_we;
   logic                              start;
   logic                              busy;
   logic                              push;
   logic                              out_free;
   logic                              csr_wr;
   logic                              csr_hit;
   logic [bzeval_pkg::NP_W-1:0]       num_points_ff;
   logic [bzeval_pkg::NP_W-1:0]       num_points_in;
   logic [bzeval_pkg::CNT_W-1:0]      n_eff;
   logic [bzeval_pkg::T_W-1:0]        t_ff;
   logic [bzeval_pkg::T_W-1:0]        t_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   bzeval_pkg::rsp_type               rsp_data_ff;
   bzeval_pkg::rsp_type               rsp_data_in;
   bzeval_pkg::point_type             res_ff;
   bzeval_pkg::point_type             res_in;
   bzeval_pkg::point_type             load_pt;
   bzeval_pkg::point_type             store_rd;
   bzeval_pkg::point_type             work_rd;
   bzeval_pkg::point_type             wb_data;
   bzeval_pkg::rd_tag_type            rd_tag;
   bzeval_pkg::wb_type                wb;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = busy;
   assign load_we   = req_acc && (req_data.action == bzeval_pkg::ACT_LOAD)
                      && (int'(req_data.point_index) < bzeval_pkg::MAX_POINTS);
   assign start     = req_acc && (req_data.action == bzeval_pkg::ACT_EVAL);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      load_pt.x = req_data.point_x;
      load_pt.y = req_data.point_y;
      load_pt.z = req_data.point_z;
   end

   always_comb begin
      if (num_points_ff == '0) begin
         n_eff = bzeval_pkg::CNT_W'(1);
      end else if (int'(num_points_ff) > bzeval_pkg::MAX_POINTS) begin
         n_eff = bzeval_pkg::CNT_W'(bzeval_pkg::MAX_POINTS);
      end else begin
         n_eff = bzeval_pkg::CNT_W'(num_points_ff);
      end
   end

   always_comb begin
      t_in = t_ff;
      if (start) begin
         if (int'(req_data.curve_param) > bzeval_pkg::ONE_Q16) begin
            t_in = bzeval_pkg::T_W'(bzeval_pkg::ONE_Q16);
         end else begin
            t_in = req_data.curve_param;
         end
      end
   end

   always_comb begin
      res_in = wb.res_en ? wb_data : res_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (push) begin
         rsp_valid_in        = 1'b1;
         rsp_data_in.curve_x = res_ff.x;
         rsp_data_in.curve_y = res_ff.y;
         rsp_data_in.curve_z = res_ff.z;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_hit    = (csr_paddr[bzeval_pkg::CSR_ADDR_W-1:bzeval_pkg::CSR_IDX_LSB]
                        == bzeval_pkg::CSR_IDX_NUM_POINTS);
   assign num_points_in = (csr_wr && csr_hit) ? csr_pwdata[bzeval_pkg::NP_W-1:0]
                                              : num_points_ff;
   assign csr_prdata = csr_hit ? bzeval_pkg::CSR_DATA_W'(num_points_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= bzeval_pkg::NP_W'(bzeval_pkg::NP_RESET);
         rsp_valid_ff  <= 1'b0;
      end else begin
         num_points_ff <= num_points_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bzeval_vec_mem u_point_mem (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_idx  (bzeval_pkg::IDX_W'(req_data.point_index)),
      .wr_data (load_pt),
      .rd_idx  (rd_tag.idx),
      .rd_data (store_rd)
   );

   bzeval_vec_mem u_work_mem (
      .clock   (clock),
      .wr_en   (wb.wr_en),
      .wr_idx  (wb.idx),
      .wr_data (wb_data),
      .rd_idx  (rd_tag.idx),
      .rd_data (work_rd)
   );

   bzeval_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .n_pts    (n_eff),
      .res_en   (wb.res_en),
      .out_free (out_free),
      .rd_tag   (rd_tag),
      .busy     (busy),
      .push     (push)
   );

   bzeval_lerp_unit u_lerp (
      .clock      (clock),
      .reset      (reset),
      .rd_tag     (rd_tag),
      .curve_t    (t_ff),
      .store_data (store_rd),
      .work_data  (work_rd),
      .wb         (wb),
      .wb_data    (wb_data)
   );

endmodule

>>> hw/rtl/bzeval_checker.sv
// ----------------------------------------------------------------------------
// Bezier curve point evaluator port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "bezier_curve_point_eval_unit_macros.svh"

module bzeval_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  bzeval_pkg::req_type                 req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  bzeval_pkg::rsp_type                 rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bzeval_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [bzeval_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [bzeval_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic                                csr_pready
);

   logic eval_acc;
   logic load_acc;
   logic np_wr;
   logic np_rd;

   assign eval_acc = req_valid && !req_stall && (req_data.action == bzeval_pkg::ACT_EVAL);
   assign load_acc = req_valid && !req_stall && (req_data.action == bzeval_pkg::ACT_LOAD);
   assign np_rd    = (csr_paddr[bzeval_pkg::CSR_ADDR_W-1:bzeval_pkg::CSR_IDX_LSB]
                      == bzeval_pkg::CSR_IDX_NUM_POINTS);
   assign np_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready && np_rd;

   `BZEVAL_ASSERT_NEXT(a_rsp_hold, !reset && rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled response changed")
   `BZEVAL_ASSERT_NEXT(a_eval_busy, !reset && eval_acc, req_stall,
      "evaluate request not followed by stall")
   `BZEVAL_ASSERT_NEXT(a_load_silent, !reset && load_acc && !rsp_valid, !rsp_valid,
      "load request produced a response")
   `BZEVAL_ASSERT_NEXT(a_np_readback, !reset && np_wr,
      !np_rd || (csr_prdata[bzeval_pkg::NP_W-1:0]
                 == $past(csr_pwdata[bzeval_pkg::NP_W-1:0])),
      "num_points readback mismatch")

endmodule

bind bezier_curve_point_eval_unit bzeval_checker u_bzeval_checker (.*);
